FILE: rtl/core/rgbac_pkg.sv
// Shared types and constants for the RGBA8 canvas compositor.
// Holds the command and result payload structs, pixel layout and operation codes.
// No dependencies.
package rgbac_pkg;

	// Field widths fixed by the command format.
	localparam int IDX_W = 16;
	localparam int ACT_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// Operation codes.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_BLEND = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PIXELS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [ACT_W-1:0]      ACTIVE_RESET = 17'd65536;
	localparam logic [CFG_DATA_W-1:0] BG_RESET     = 32'hFF2D2D2D;

	localparam logic [7:0] FULL_ALPHA = 8'd255;

	// One canvas word: red in the low byte.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] pixel_index;
		logic [7:0]       src_red;
		logic [7:0]       src_green;
		logic [7:0]       src_blue;
		logic [7:0]       src_alpha;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       index_bad;
	} result_t;

	// Outcome of a blend: whether the canvas word changes, and its new value.
	typedef struct packed {
		logic   wr;
		pixel_t pix;
	} blend_res_t;

endpackage

FILE: rtl/core/rgbac_blend.sv
// Over-operator blend datapath for one RGBA8 pixel.
// Depends on rgbac_pkg for the pixel and blend result types.
module rgbac_blend
	import rgbac_pkg::*;
(
	input  pixel_t     src,
	input  pixel_t     dst,
	output blend_res_t res
);

	logic [7:0]  inv_a;
	logic [16:0] sum_r;
	logic [16:0] sum_g;
	logic [16:0] sum_b;

	// Three independent multiply-adds, one per color channel.
	always_comb begin
		inv_a = FULL_ALPHA - src.alpha;
		sum_r = 17'(16'(src.red) * 16'(src.alpha)) + 17'(16'(dst.red) * 16'(inv_a));
		sum_g = 17'(16'(src.green) * 16'(src.alpha)) + 17'(16'(dst.green) * 16'(inv_a));
		sum_b = 17'(16'(src.blue) * 16'(src.alpha)) + 17'(16'(dst.blue) * 16'(inv_a));
	end

	// Transparent leaves the pixel alone, opaque copies it, anything else mixes.
	always_comb begin
		res.wr = (src.alpha != 8'd0);
		if (src.alpha == FULL_ALPHA) begin
			res.pix = src;
		end else begin
			res.pix.red   = sum_r[15:8];
			res.pix.green = sum_g[15:8];
			res.pix.blue  = sum_b[15:8];
			res.pix.alpha = FULL_ALPHA;
		end
	end

endmodule

FILE: rtl/core/rgba_canvas_alpha_compositor.sv
// Top level of the RGBA8 canvas compositor: canvas memory, command pipeline, config.
// Depends on rgbac_pkg and rgbac_blend.
//
// Channel   Signals                        Direction  Transfer
// command   start, busy, cmd               in         start high while busy low
// result    result_valid, result           out        one cycle strobe, no backpressure
// config    cfg_we, cfg_index, cfg_data    in         cfg_we high at a clock edge
//
// The accept edge registers the command and issues the canvas read; in stage 1
// the block clears or blends the word and writes it back, or returns it for a read.
// busy is high during stage 1, so no new command is taken until stage 1 ends;
// the read-modify-write on the single-port canvas sets that limit.
// A read result appears on the cycle after its command is accepted.
// arst_n clears control state and the config registers; the canvas is not cleared.
// The result receiver cannot stall the block.
module rgba_canvas_alpha_compositor
	import rgbac_pkg::*;
#(
	parameter int CANVAS_PIXELS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  result_valid,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(CANVAS_PIXELS);
	localparam int LW = (AW + 1 > ACT_W) ? AW + 1 : ACT_W;
	localparam logic [LW-1:0] CANVAS_LIM = LW'(CANVAS_PIXELS);

	logic [ACT_W-1:0] active_q;
	pixel_t           bg_q;

	logic             accept;
	logic [AW+IDX_W-1:0] idx_wide;
	logic [AW-1:0]    addr;
	logic [LW-1:0]    idx_l;
	logic [LW-1:0]    act_l;
	logic             ok;

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic             ok_s1;
	logic [AW-1:0]    addr_s1;
	pixel_t           src_s1;
	pixel_t           rd_data_s1;

	pixel_t           canvas_mem [CANVAS_PIXELS];
	blend_res_t       blend;
	logic             wr_en;
	pixel_t           wr_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			bg_q     <= pixel_t'(BG_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_PIXELS: active_q <= cfg_data[ACT_W-1:0];
				CFG_BACKGROUND:    bg_q     <= pixel_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Command acceptance and range check against the active and physical size.
	always_comb begin
		accept   = start && !busy;
		idx_wide = {{AW{1'b0}}, cmd.pixel_index};
		addr     = idx_wide[AW-1:0];
		idx_l    = {{(LW-IDX_W){1'b0}}, cmd.pixel_index};
		act_l    = {{(LW-ACT_W){1'b0}}, active_q};
		ok       = (idx_l < act_l) && (idx_l < CANVAS_LIM);
	end

	assign busy = valid_s1;

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= cmd.op;
			ok_s1   <= ok;
			addr_s1 <= addr;
			src_s1  <= '{alpha: cmd.src_alpha, blue: cmd.src_blue,
				green: cmd.src_green, red: cmd.src_red};
		end
	end

	rgbac_blend u_blend (
		.src (src_s1),
		.dst (rd_data_s1),
		.res (blend)
	);

	// Write-back selection for clear and blend.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = blend.pix;
		if (valid_s1 && ok_s1) begin
			unique case (op_s1)
				OP_CLEAR: begin
					wr_en   = 1'b1;
					wr_data = bg_q;
				end
				OP_BLEND: begin
					wr_en   = blend.wr;
					wr_data = blend.pix;
				end
				default: ;
			endcase
		end
	end

	// Canvas memory: one read at accept, one write in stage 1; they never overlap
	// on the same entry because busy blocks the next accept.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			canvas_mem[addr_s1] <= wr_data;
		end
		if (accept) begin
			rd_data_s1 <= canvas_mem[addr];
		end
	end

	// Read result, shown during stage 1.
	always_comb begin
		result_valid = valid_s1 && (op_s1 == OP_READ);
		if (ok_s1) begin
			result.out_red   = rd_data_s1.red;
			result.out_green = rd_data_s1.green;
			result.out_blue  = rd_data_s1.blue;
			result.out_alpha = rd_data_s1.alpha;
			result.index_bad = 1'b0;
		end else begin
			result.out_red   = 8'd0;
			result.out_green = 8'd0;
			result.out_blue  = 8'd0;
			result.out_alpha = 8'd0;
			result.index_bad = 1'b1;
		end
	end

`ifndef SYNTH
	// A command occupies exactly one busy cycle.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// An accepted read yields a result on the next cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_READ) |=> result_valid)
		else $error("read command without result");

	// A result only follows an accepted read.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && cmd.op == OP_READ))
		else $error("result without read command");

	// Out-of-range reads return an all-zero pixel.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.index_bad) |-> (result.out_red == 8'd0 &&
		result.out_green == 8'd0 && result.out_blue == 8'd0 &&
		result.out_alpha == 8'd0))
		else $error("flagged read carries pixel data");
`endif

endmodule
